@@ hdl/led_matrix_frame_scanner_assert.svh @@
// Assertion macros for the LED matrix frame scanner.
// Expects signals named clock and reset in the scope of each use.
`ifndef LED_MATRIX_FRAME_SCANNER_ASSERT_SVH
`define LED_MATRIX_FRAME_SCANNER_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define LMFS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("led matrix scanner: same-cycle check failed");

// Next-cycle implication, quiet while reset is high.
`define LMFS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("led matrix scanner: next-cycle check failed");

`endif

@@ hdl/lmfs_pkg.sv @@
// Shared types and constants of the LED matrix frame scanner.
// No dependencies; used by every module of the block but lmfs_fifo.
`timescale 1ns / 1ps
`default_nettype none

package lmfs_pkg;

   localparam int FRAME_BYTES     = 64;
   localparam int ROWS            = 16;
   localparam int ADDR_W          = $clog2(FRAME_BYTES);
   localparam int ROW_W           = $clog2(ROWS);
   localparam int BIT_W           = 4;
   localparam int WORDS           = FRAME_BYTES / 2;
   localparam int WORD_W          = $clog2(WORDS);
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int OUT_DEPTH       = 4;

   localparam logic ACTION_TICK = 1'b1;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [ROW_W-1:0]    row;
      logic [BIT_W-1:0]    bitpos;
      logic                load;
      logic [ADDR_W-1:0]   addr;
      logic [7:0]          data;
   } qent_type;

   typedef struct packed {
      logic row_bit;
      logic panel_a_bit;
      logic panel_b_bit;
      logic latch_pulse;
   } rsp_type;

   typedef struct packed {
      logic copy_active;
      logic pop;
   } back_status_type;

   localparam int QENT_W = $bits(qent_type);
   localparam int RSP_W  = $bits(rsp_type);

endpackage

`default_nettype wire

@@ hdl/lmfs_fifo.sv @@
// Small first-in first-out buffer of flip-flops with occupancy count.
// No package dependency; used for the command queue and the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module lmfs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [WIDTH-1:0]             din,
   input  wire logic                         pop,
   output logic      [WIDTH-1:0]             dout,
   output logic                              full,
   output logic                              empty,
   output logic      [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout  = mem_ff[rd_ptr_ff];
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

`default_nettype wire

@@ hdl/lmfs_front.sv @@
// Front end: classifies items, tracks receive count, pending frame and scan position.
// Depends on lmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmfs_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic              action,
   input  wire logic [7:0]        rx_byte,
   output lmfs_pkg::qent_type     entry
);

   import lmfs_pkg::*;

   logic [ADDR_W-1:0] count_ff, count_in;
   logic              pending_ff, pending_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              is_tick;
   logic              load;

   assign is_tick = (action == ACTION_TICK);
   assign load    = (row_ff == '0) && (bit_ff == '0) && pending_ff;

   always_comb begin
      entry.kind   = is_tick ? KIND_TICK : KIND_BYTE;
      entry.row    = row_ff;
      entry.bitpos = bit_ff;
      entry.load   = load;
      entry.addr   = count_ff;
      entry.data   = rx_byte;
   end

   always_comb begin
      count_in   = count_ff;
      pending_in = pending_ff;
      row_in     = row_ff;
      bit_in     = bit_ff;
      if (push) begin
         if (is_tick) begin
            // drop the pending flag once the copy is scheduled
            if (load) begin
               pending_in = 1'b0;
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == '1) begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            count_in = count_ff + 1'b1;
            if (count_ff == '1) begin
               pending_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pending_ff <= 1'b0;
         row_ff     <= '0;
         bit_ff     <= '0;
      end else begin
         count_ff   <= count_in;
         pending_ff <= pending_in;
         row_ff     <= row_in;
         bit_ff     <= bit_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/lmfs_back.sv @@
// Back end: receive and display memories, frame copy sweep, bit readout, result buffer.
// Depends on lmfs_pkg and lmfs_fifo.
`timescale 1ns / 1ps
`default_nettype none

module lmfs_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  lmfs_pkg::qent_type           head,
   output lmfs_pkg::back_status_type    status,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output lmfs_pkg::rsp_type            rsp_data
);

   import lmfs_pkg::*;

   localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

   // even bytes are the high half of each display word, odd bytes the low half
   logic [7:0]        even_mem [WORDS];
   logic [7:0]        odd_mem  [WORDS];
   logic [15:0]       disp_mem [WORDS];

   logic              copy_active_ff, copy_active_in;
   logic              copy_done_ff, copy_done_in;
   logic              loaded_ff, loaded_in;
   logic [WORD_W:0]   idx_ff, idx_in;
   logic [7:0]        rd_even_ff, rd_odd_ff;
   logic              wr_pend_ff;
   logic [WORD_W-1:0] wr_addr_ff;

   logic [15:0]       disp_a_ff, disp_b_ff;
   logic              s1_valid_ff;
   logic              s1_loaded_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [BIT_W-1:0]  s1_bit_ff;

   logic              is_tick;
   logic              room;
   logic              pop;
   logic              start_copy;
   logic              byte_wr;
   logic [OCNT_W-1:0] out_count;
   logic              out_full;
   logic              out_empty;
   logic [OCNT_W:0]   out_used;
   rsp_type           out_din;
   logic [15:0]       word_a, word_b;

   assign is_tick    = (head.kind == KIND_TICK);
   assign out_used   = {1'b0, out_count} + {{OCNT_W{1'b0}}, s1_valid_ff};
   assign room       = (out_used < (OCNT_W + 1)'(OUT_DEPTH));
   assign start_copy = head_valid && is_tick && head.load && !copy_done_ff && !copy_active_ff;
   assign pop        = head_valid && !copy_active_ff
                       && (!is_tick || ((!head.load || copy_done_ff) && room));
   assign byte_wr    = pop && !is_tick;

   assign status.copy_active = copy_active_ff;
   assign status.pop         = pop;

   always_comb begin
      copy_active_in = copy_active_ff;
      copy_done_in   = copy_done_ff;
      loaded_in      = loaded_ff;
      idx_in         = idx_ff;
      if (start_copy) begin
         copy_active_in = 1'b1;
         idx_in         = '0;
      end else if (copy_active_ff) begin
         // the extra step at the top index lets the last word land before the tick reads it
         if (idx_ff[WORD_W]) begin
            copy_active_in = 1'b0;
            copy_done_in   = 1'b1;
            loaded_in      = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (pop && is_tick) begin
         copy_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         copy_active_ff <= 1'b0;
         copy_done_ff   <= 1'b0;
         loaded_ff      <= 1'b0;
         idx_ff         <= '0;
         wr_pend_ff     <= 1'b0;
         s1_valid_ff    <= 1'b0;
      end else begin
         copy_active_ff <= copy_active_in;
         copy_done_ff   <= copy_done_in;
         loaded_ff      <= loaded_in;
         idx_ff         <= idx_in;
         wr_pend_ff     <= copy_active_ff && !idx_ff[WORD_W];
         s1_valid_ff    <= pop && is_tick;
      end
   end

   // receive store: byte writes, copy-sweep reads
   always_ff @(posedge clock) begin
      if (byte_wr && !head.addr[0]) begin
         even_mem[head.addr[ADDR_W-1:1]] <= head.data;
      end
      if (byte_wr && head.addr[0]) begin
         odd_mem[head.addr[ADDR_W-1:1]] <= head.data;
      end
      rd_even_ff <= even_mem[idx_ff[WORD_W-1:0]];
      rd_odd_ff  <= odd_mem[idx_ff[WORD_W-1:0]];
      wr_addr_ff <= idx_ff[WORD_W-1:0];
   end

   // display store: copy-sweep writes, two row reads per tick
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         disp_mem[wr_addr_ff] <= {rd_even_ff, rd_odd_ff};
      end
      disp_a_ff <= disp_mem[{1'b0, head.row}];
      disp_b_ff <= disp_mem[{1'b1, head.row}];
   end

   always_ff @(posedge clock) begin
      s1_loaded_ff <= loaded_ff;
      s1_row_ff    <= head.row;
      s1_bit_ff    <= head.bitpos;
   end

   assign word_a = s1_loaded_ff ? disp_a_ff : '0;
   assign word_b = s1_loaded_ff ? disp_b_ff : '0;

   always_comb begin
      out_din.row_bit     = ((s1_row_ff + s1_bit_ff) == '1);
      out_din.panel_a_bit = word_a[s1_bit_ff];
      out_din.panel_b_bit = word_b[s1_bit_ff];
      out_din.latch_pulse = (s1_bit_ff == '1);
   end

   lmfs_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (s1_valid_ff),
      .din   (out_din),
      .pop   (rsp_valid && rsp_ready),
      .dout  (rsp_data),
      .full  (out_full),
      .empty (out_empty),
      .count (out_count)
   );

   assign rsp_valid = !out_empty || (out_full && 1'b0);

endmodule

`default_nettype wire

@@ hdl/led_matrix_frame_scanner.sv @@
// Top level of the LED matrix frame scanner: front end, command queue, back end.
// Depends on lmfs_pkg, lmfs_front, lmfs_fifo, lmfs_back and the assertion macros.
//
// Scans two 16x16 LED panels one bit per tick item and stores frame bytes from byte
// items. Items enter at one per cycle while the command queue has room. Byte and tick
// items pass in order through the queue, so a frame copy sees exactly the bytes that
// came before its tick. The tick at row 0, bit 0 with a full frame pending runs a copy
// sweep of the receive memory into the display memory, one 16-bit word a cycle over 32
// words; the back end holds during the sweep and the front end keeps taking items until
// the queue fills. Results wait in a four-entry buffer, so a stalled rsp side does not
// block input until the queue also fills.
// The display reads as all zeros until the first frame has been copied.
`timescale 1ns / 1ps
`default_nettype none
`include "led_matrix_frame_scanner_assert.svh"

module led_matrix_frame_scanner #(
   parameter int QUEUE_DEPTH = lmfs_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_row_bit,
   output logic             rsp_panel_a_bit,
   output logic             rsp_panel_b_bit,
   output logic             rsp_latch_pulse
);

   import lmfs_pkg::*;

   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   qent_type          front_entry;
   logic [QENT_W-1:0] q_dout;
   qent_type          q_head;
   logic              q_full;
   logic              q_empty;
   logic [QCNT_W-1:0] q_count;
   logic              req_xfer;
   back_status_type   back_status;
   rsp_type           rsp_data;

   // accept a transfer whenever the queue has a free slot
   assign req_ready = !q_full;
   assign req_xfer  = req_valid && req_ready;

   lmfs_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (req_xfer),
      .action  (req_action),
      .rx_byte (req_rx_byte),
      .entry   (front_entry)
   );

   lmfs_fifo #(
      .WIDTH (QENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_xfer),
      .din   (front_entry),
      .pop   (back_status.pop),
      .dout  (q_dout),
      .full  (q_full),
      .empty (q_empty),
      .count (q_count)
   );

   assign q_head = qent_type'(q_dout);

   lmfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_empty),
      .head       (q_head),
      .status     (back_status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_row_bit     = rsp_data.row_bit;
   assign rsp_panel_a_bit = rsp_data.panel_a_bit;
   assign rsp_panel_b_bit = rsp_data.panel_b_bit;
   assign rsp_latch_pulse = rsp_data.latch_pulse;

   // hold the queue head for the whole copy sweep
   `LMFS_ASSERT_SAME(a_no_pop_in_copy, back_status.copy_active, !back_status.pop)
   // a copy sweep is still active in the cycle after it starts
   `LMFS_ASSERT_NEXT(a_copy_lasts, $rose(back_status.copy_active), back_status.copy_active)
   // pop only from an occupied queue
   `LMFS_ASSERT_SAME(a_pop_nonempty, back_status.pop, q_count != '0)

endmodule

`default_nettype wire

@@ tb/sv/led_matrix_frame_scanner_tb.sv @@
// Self-checking testbench for the LED matrix frame scanner top level.
// Depends on lmfs_pkg and led_matrix_frame_scanner; predicts every scan bit in-line.
`timescale 1ns / 1ps

module led_matrix_frame_scanner_tb;

   // Item mix and run limits.
   localparam int RANDOM_ITEMS   = 800;
   localparam int HOLD_AT        = 150;   // results seen before the long receiver hold-off
   localparam int HOLD_CYCLES    = 300;
   localparam int PAUSE_AT       = 500;   // items issued before the sender drains the block
   localparam int MODE_PERIOD    = 256;   // cycles between changes of idling pressure
   localparam int DRAIN_CYCLES   = 64;    // copy sweep plus pipeline and buffers
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      lmfs_pkg::kind_type kind;
      logic [7:0]         value;
   } scan_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_action = lmfs_pkg::KIND_BYTE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_row_bit;
   logic       rsp_panel_a_bit;
   logic       rsp_panel_b_bit;
   logic       rsp_latch_pulse;

   // Items waiting to be offered, and scan bits predicted but not yet seen.
   scan_item_type       pend_q[$];
   lmfs_pkg::rsp_type   scan_bits_q[$];

   // Predicted block state; the display starts blank.
   logic [7:0]  rx_mem [lmfs_pkg::FRAME_BYTES];
   logic [5:0]  fill_count = '0;
   logic        frame_ready = 1'b0;
   logic [15:0] disp_words [2*lmfs_pkg::ROWS] = '{default: '0};
   logic [3:0]  scan_row = '0;
   logic [3:0]  scan_bit = '0;

   int errors = 0;
   int queued_bytes = 0;
   int bytes_in = 0;
   int ticks_in = 0;
   int frame_loads = 0;
   int latches_seen = 0;

   led_matrix_frame_scanner dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_bit     (rsp_row_bit),
      .rsp_panel_a_bit (rsp_panel_a_bit),
      .rsp_panel_b_bit (rsp_panel_b_bit),
      .rsp_latch_pulse (rsp_latch_pulse)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Scan predictor
   // ---------------------------------------------------------------------------

   // Store one received byte; the 64th byte of a frame wraps the count and
   // marks the frame as ready for the next row 0, bit 0.
   function automatic void store_frame_byte(input logic [7:0] value);
      rx_mem[fill_count] = value;
      fill_count = fill_count + 6'd1;
      if (fill_count == 6'd0)
         frame_ready = 1'b1;
   endfunction

   // Work out the serial bits for one tick and advance the scan position.
   function automatic lmfs_pkg::rsp_type next_scan_bits();
      lmfs_pkg::rsp_type bits;
      logic [15:0]       row_sel;
      // A pending frame lands in the display words only at the top of the scan.
      if (scan_row == 4'd0 && scan_bit == 4'd0 && frame_ready) begin
         for (int r = 0; r < lmfs_pkg::ROWS; r++) begin
            disp_words[r]                 = {rx_mem[2*r], rx_mem[2*r+1]};
            disp_words[lmfs_pkg::ROWS+r]  = {rx_mem[2*r+32], rx_mem[2*r+33]};
         end
         frame_ready = 1'b0;
         frame_loads++;
      end
      row_sel          = 16'h8000 >> scan_row;
      bits.row_bit     = row_sel[scan_bit];
      bits.panel_a_bit = disp_words[scan_row][scan_bit];
      bits.panel_b_bit = disp_words[lmfs_pkg::ROWS + scan_row][scan_bit];
      bits.latch_pulse = (scan_bit == 4'd15);
      // Wrap the bit position into the next row after the latch bit.
      if (scan_bit == 4'd15)
         scan_row = scan_row + 4'd1;
      scan_bit = scan_bit + 4'd1;
      return bits;
   endfunction

   function automatic void check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s mismatch: expected %0b, got %0b", name, want, got);
         errors++;
      end
   endfunction

   // Draw an idle gap: none in calm stretches, mostly short, now and then long.
   function automatic int pick_gap(input int busy_pct);
      if (busy_pct == 0 || $urandom_range(0, 99) >= busy_pct)
         return 0;
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_busy();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 25;
         default: return 60;
      endcase
   endfunction

   function automatic void queue_item(input lmfs_pkg::kind_type kind, input logic [7:0] value);
      scan_item_type it;
      it.kind  = kind;
      it.value = value;
      pend_q.push_back(it);
      if (kind == lmfs_pkg::KIND_BYTE)
         queued_bytes++;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: offer queued items with random gaps, and once drain the block.
   // ---------------------------------------------------------------------------
   int  issued = 0;
   int  send_gap = 0;
   int  send_busy = 0;
   int  send_cycle = 0;
   int  drv_ticks = 0;
   int  drv_results = 0;
   bit  pause_done = 1'b0;

   always @(posedge clock) begin : drive_proc
      scan_item_type nxt;
      logic          fire;
      logic          offer;
      if (reset) begin
         req_valid   <= 1'b0;
         req_action  <= lmfs_pkg::KIND_BYTE;
         req_rx_byte <= 8'h00;
      end else begin
         send_cycle++;
         if (send_cycle % MODE_PERIOD == 0)
            send_busy = pick_busy();
         fire = req_valid && req_ready;
         if (fire && req_action == lmfs_pkg::ACTION_TICK)
            drv_ticks++;
         if (rsp_valid && rsp_ready)
            drv_results++;
         if (fire)
            send_gap = pick_gap(send_busy);
         // Hold the current item until its transfer; pick the next one only
         // when the channel is free, so valid sees a single update per edge.
         offer = req_valid && !fire;
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (issued == PAUSE_AT && !pause_done) begin
               if (drv_results == drv_ticks)
                  pause_done = 1'b1;
            end else if (pend_q.size() != 0) begin
               nxt = pend_q.pop_front();
               req_action  <= nxt.kind;
               req_rx_byte <= nxt.value;
               issued++;
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: random stalls plus one long hold-off that backs up the block.
   // ---------------------------------------------------------------------------
   int sink_count = 0;
   int sink_gap = 0;
   int sink_busy = 0;
   int sink_cycle = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin : sink_proc
      logic take;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         sink_cycle++;
         if (sink_cycle % MODE_PERIOD == MODE_PERIOD / 2)
            sink_busy = pick_busy();
         if (rsp_valid && rsp_ready)
            sink_count++;
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (!hold_done && sink_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            take      = 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            take = 1'b0;
         end else begin
            take     = 1'b1;
            sink_gap = pick_gap(sink_busy);
         end
         rsp_ready <= take;
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: predict on every input transfer, check every result transfer.
   // Both channels are handled here so the order within an edge is fixed.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_proc
      lmfs_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_action == lmfs_pkg::KIND_TICK) begin
               scan_bits_q.push_back(next_scan_bits());
               ticks_in++;
            end else begin
               store_frame_byte(req_rx_byte);
               bytes_in++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (scan_bits_q.size() == 0) begin
               $error("scan bits transfer with no tick waiting for it");
               errors++;
            end else begin
               want = scan_bits_q.pop_front();
               check_field("row_bit",     want.row_bit,     rsp_row_bit);
               check_field("panel_a_bit", want.panel_a_bit, rsp_panel_a_bit);
               check_field("panel_b_bit", want.panel_b_bit, rsp_panel_b_bit);
               check_field("latch_pulse", want.latch_pulse, rsp_latch_pulse);
               if (rsp_latch_pulse)
                  latches_seen++;
            end
         end
      end
   end

   // Stop the run when neither channel moves for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin : watchdog_proc
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("led_matrix_frame_scanner_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------------
   initial begin : main_proc
      int target;
      int left;
      int count;
      target = 0;
      // Directed: a full row of ticks plus one on the blank display (latch on the
      // last bit of the row), then byte extremes that must not move the scan position.
      for (int i = 0; i < 17; i++)
         queue_item(lmfs_pkg::KIND_TICK, 8'($urandom));
      queue_item(lmfs_pkg::KIND_BYTE, 8'h00);
      queue_item(lmfs_pkg::KIND_BYTE, 8'hFF);
      queue_item(lmfs_pkg::KIND_BYTE, 8'h5A);
      queue_item(lmfs_pkg::KIND_BYTE, 8'hA5);
      queue_item(lmfs_pkg::KIND_TICK, 8'hFF);
      target = pend_q.size() + RANDOM_ITEMS;

      // Random: complete frames (sometimes with ticks mixed in, so a later
      // frame may overwrite the store before the copy) and, more often, long
      // tick runs that cross the top of the scan, with a little noise.
      while (pend_q.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               left = lmfs_pkg::FRAME_BYTES - (queued_bytes % lmfs_pkg::FRAME_BYTES);
               while (left > 0) begin
                  if ($urandom_range(0, 5) == 0) begin
                     queue_item(lmfs_pkg::KIND_TICK, 8'($urandom));
                  end else begin
                     queue_item(lmfs_pkg::KIND_BYTE, 8'($urandom));
                     left--;
                  end
               end
            end
            9: begin
               count = $urandom_range(1, 20);
               repeat (count)
                  queue_item(lmfs_pkg::kind_type'($urandom_range(0, 1)), 8'($urandom));
            end
            default: begin
               count = $urandom_range(32, 300);
               // keep the last tick run from overshooting the item budget
               if (count > target - pend_q.size())
                  count = target - pend_q.size();
               repeat (count)
                  queue_item(lmfs_pkg::KIND_TICK, 8'($urandom));
            end
         endcase
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for every item to go in and every predicted result to come out.
      do
         @(negedge clock);
      while (pend_q.size() != 0 || req_valid || scan_bits_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (scan_bits_q.size() != 0) begin
         $error("%0d predicted scan bit transfers never arrived", scan_bits_q.size());
         errors += scan_bits_q.size();
      end

      $display("covered %0d byte and %0d tick transfers, %0d frame loads, %0d latch strobes",
               bytes_in, ticks_in, frame_loads, latches_seen);
      $display("receiver hold-off of %0d cycles and one full sender drain included",
               HOLD_CYCLES);
      if (errors == 0) begin
         $display("led_matrix_frame_scanner_tb: done, clean");
      end else begin
         $display("led_matrix_frame_scanner_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/lmfs_pkg.sv
hdl/lmfs_fifo.sv
hdl/lmfs_front.sv
hdl/lmfs_back.sv
hdl/led_matrix_frame_scanner.sv
tb/sv/led_matrix_frame_scanner_tb.sv
